// ----- sv/nlg_pkg.sv -----
// Shared types, constants and fixed-point helpers for the leapfrog n-body step.
// Used by nlg_arith and by the top level nbody_leapfrog_gravity_step.
// No dependencies.
package nlg_pkg;

    // body table size
    localparam int MAX_BODIES = 16;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);

    // shared arithmetic unit sizing
    localparam int WIDE_W      = 128;
    localparam int DIV_STEPS   = WIDE_W;
    localparam int SQRT_STEPS  = 34;
    localparam int SQRT_ALIGN  = WIDE_W - 2 * SQRT_STEPS;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_CONST = 2'd1;

    // reset values of the configuration registers
    localparam logic [31:0] TIME_STEP_RST  = 32'd655;
    localparam logic [31:0] GRAV_CONST_RST = 32'd6553600;

    // input word kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } arith_op_t;

    // request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    // one entry of the body memory
    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [47:0] acc_x;
        logic [47:0] acc_y;
    } body_t;

    // clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sh07FFFFFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -36'sh080000000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // clamp to the signed 48-bit range
    function automatic logic [47:0] sat48(input logic signed [49:0] v);
        logic [47:0] r;
        if (v > 50'sh07FFFFFFFFFFF)
            r = 48'h7FFF_FFFF_FFFF;
        else if (v < -50'sh0800000000000)
            r = 48'h8000_0000_0000;
        else
            r = v[47:0];
        return r;
    endfunction

endpackage

// ----- sv/nlg_arith.sv -----
// Shared multi-cycle arithmetic unit: shift-add multiply, restoring divide
// and digit-by-digit square root on 128-bit operands, one step per cycle.
// Depends on nlg_pkg.
module nlg_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  nlg_pkg::arith_req_t req,
    input  logic [127:0]        a,
    input  logic [127:0]        b,
    output logic                done,
    output logic [127:0]        result
);
    import nlg_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    arith_op_t         op_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [127:0]      acc_reg;
    logic [127:0]      x_reg;
    logic [127:0]      y_reg;
    logic [128:0]      rem_reg;

    logic [128:0]      shifted;
    logic [128:0]      subtr;
    logic [128:0]      diff;
    logic              ge;

    // trial subtract shared by divide and square root
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            shifted = {rem_reg[126:0], x_reg[127:126]};
            subtr   = {acc_reg[126:0], 2'b01};
        end
        else
        begin
            shifted = {rem_reg[127:0], x_reg[127]};
            subtr   = {1'b0, y_reg};
        end
        ge   = shifted >= subtr;
        diff = shifted - subtr;
    end

    // control: busy flag, step counter, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= (req.op == OP_SQRT) ? STEP_W'(SQRT_STEPS) : STEP_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                unique case (op_reg) inside
                    OP_MUL:
                    begin
                        if (y_reg == '0)
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    OP_DIV, OP_SQRT:
                    begin
                        cnt_reg <= cnt_reg - STEP_W'(1);
                        if (cnt_reg == STEP_W'(1))
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    // datapath: one multiply bit or one quotient/root digit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            rem_reg <= '0;
            y_reg   <= b;
            x_reg   <= (req.op == OP_SQRT) ? (a << SQRT_ALIGN) : a;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                if (y_reg[0])
                    acc_reg <= acc_reg + x_reg;
                x_reg <= x_reg << 1;
                y_reg <= y_reg >> 1;
            end
            else
            begin
                x_reg   <= (op_reg == OP_SQRT) ? (x_reg << 2) : (x_reg << 1);
                rem_reg <= ge ? diff : shifted;
                acc_reg <= {acc_reg[126:0], ge};
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// ----- sv/nbody_leapfrog_gravity_step.sv -----
// Two-dimensional gravitational n-body integrator (kick-drift-kick leapfrog),
// signed Q16.16 values, body table in one synchronous memory of up to 16 entries.
// Depends on nlg_pkg and nlg_arith.
//
// An add word answers with one word (status 1 when the table is full). A step
// word runs through the table three times: half kick and drift per body,
// pairwise gravity per body pair, second half kick and report per body. All wide
// arithmetic goes through one shared unit that does a multiply at one multiplier
// bit per cycle, a 128-step divide and a 34-step square root. Each body pair
// takes four multiply and divide pairs, a root and three multiplies. Input words
// are taken only while the sequencer is idle; reported words wait in an output
// register.
module nbody_leapfrog_gravity_step (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [31:0] mass,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  body_index,
    output logic [31:0] mass_out,
    output logic [31:0] pos_x_out,
    output logic [31:0] pos_y_out,
    output logic [31:0] vel_x_out,
    output logic [31:0] vel_y_out,
    output logic        status,
    output logic        last
);
    import nlg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD,
        S_B_RD,
        S_B_LD,
        S_B_KX,
        S_B_KY,
        S_B_DX,
        S_B_DY,
        S_B_WR,
        S_B_OUT,
        S_P_RDI,
        S_P_LDI,
        S_P_RDJ,
        S_P_LDJ,
        S_P_CHK,
        S_P_SQX,
        S_P_SQY,
        S_P_SQRT,
        S_P_DEN,
        S_P_NUM,
        S_P_DIV,
        S_P_WRI,
        S_P_WRJ,
        S_P_NEXT
    } state_t;

    localparam logic [33:0] CAP33 = 34'h2_0000_0000;
    localparam logic [47:0] CAP47 = 48'h8000_0000_0000;

    // control registers
    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [1:0]       tsel_reg;
    logic             ph3_reg;
    logic             issued_reg;
    logic             out_valid_reg;
    logic [31:0]      ts_reg;
    logic [31:0]      gc_reg;

    // datapath registers
    logic [63:0]      c_reg;
    body_t            in_body_reg;
    body_t            ei_reg;
    body_t            ej_reg;
    logic [32:0]      rx_reg;
    logic [32:0]      ry_reg;
    logic [65:0]      d2_reg;
    logic [33:0]      s_reg;
    logic [127:0]     den_reg;
    logic [127:0]     num_reg;
    logic [5:0]       idx_out_reg;
    logic [31:0]      mass_out_reg;
    logic [31:0]      pos_x_out_reg;
    logic [31:0]      pos_y_out_reg;
    logic [31:0]      vel_x_out_reg;
    logic [31:0]      vel_y_out_reg;
    logic             status_reg;
    logic             last_reg;

    // body memory
    body_t            mem [MAX_BODIES];
    body_t            rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    body_t            mem_wdata;

    // arithmetic unit interface
    arith_req_t       arith_req;
    logic [127:0]     arith_a;
    logic [127:0]     arith_b;
    logic             arith_done;
    logic [127:0]     arith_res;

    // misc combinational
    logic             accept_in;
    logic             out_free;
    logic             load_out;
    logic             full;
    logic             i_last;
    logic             i2_last;
    logic             j_last;
    logic             op_state;
    logic [47:0]      acc_x_mag;
    logic [47:0]      acc_y_mag;
    logic [31:0]      vel_x_mag;
    logic [31:0]      vel_y_mag;
    logic [32:0]      rx_mag;
    logic [32:0]      ry_mag;
    logic [32:0]      rc_mag;
    logic             rc_neg;
    logic [31:0]      m_sel;
    logic [33:0]      kick_mag;
    logic [33:0]      drift_mag;
    logic [47:0]      term_mag;
    logic             term_neg;
    logic [47:0]      acc_sel;
    logic [47:0]      acc_new;

    // capped magnitude of an already shifted product
    function automatic logic [33:0] cap34(input logic [127:0] v);
        logic [33:0] r;
        if ((|v[127:34]) || (v[33:0] > CAP33))
            r = CAP33;
        else
            r = v[33:0];
        return r;
    endfunction

    // signed 32-bit add of a signed magnitude, saturated
    function automatic logic [31:0] add_sat32(input logic [31:0] x, input logic neg,
                                              input logic [33:0] mag);
        logic signed [35:0] d;
        logic signed [35:0] s;
        d = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        s = $signed({{4{x[31]}}, x}) + d;
        return sat32(s);
    endfunction

    // signed 48-bit add of a signed magnitude, saturated
    function automatic logic [47:0] add_sat48(input logic [47:0] x, input logic neg,
                                              input logic [47:0] mag);
        logic signed [49:0] d;
        logic signed [49:0] s;
        d = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        s = $signed({{2{x[47]}}, x}) + d;
        return sat48(s);
    endfunction

    // handshake and loop conditions
    assign in_ready  = (state_reg == S_IDLE);
    assign accept_in = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign full      = (count_reg >= CNT_W'(MAX_BODIES));
    assign i_last    = (i_reg + CNT_W'(1) == count_reg);
    assign i2_last   = (i_reg + CNT_W'(2) == count_reg);
    assign j_last    = (j_reg + CNT_W'(1) == count_reg);
    assign load_out  = ((state_reg == S_ADD) || (state_reg == S_B_OUT)) && out_free;

    // magnitudes and operand selection
    assign acc_x_mag = ei_reg.acc_x[47] ? -ei_reg.acc_x : ei_reg.acc_x;
    assign acc_y_mag = ei_reg.acc_y[47] ? -ei_reg.acc_y : ei_reg.acc_y;
    assign vel_x_mag = ei_reg.vel_x[31] ? -ei_reg.vel_x : ei_reg.vel_x;
    assign vel_y_mag = ei_reg.vel_y[31] ? -ei_reg.vel_y : ei_reg.vel_y;
    assign rx_mag    = rx_reg[32] ? -rx_reg : rx_reg;
    assign ry_mag    = ry_reg[32] ? -ry_reg : ry_reg;
    assign rc_mag    = tsel_reg[0] ? ry_mag : rx_mag;
    assign rc_neg    = tsel_reg[0] ? ry_reg[32] : rx_reg[32];
    assign m_sel     = tsel_reg[1] ? ei_reg.mass : ej_reg.mass;
    assign kick_mag  = cap34(arith_res >> 33);
    assign drift_mag = cap34(arith_res >> 16);

    // pair term: capped quotient, sign flipped for the second body
    always_comb
    begin
        if ((|arith_res[127:48]) || (arith_res[47:0] > CAP47))
            term_mag = CAP47;
        else
            term_mag = arith_res[47:0];
        term_neg = rc_neg ^ tsel_reg[1];
        case (tsel_reg)
            2'd0:    acc_sel = ei_reg.acc_x;
            2'd1:    acc_sel = ei_reg.acc_y;
            2'd2:    acc_sel = ej_reg.acc_x;
            default: acc_sel = ej_reg.acc_y;
        endcase
        acc_new = add_sat48(acc_sel, term_neg, term_mag);
    end

    // arithmetic unit operands
    always_comb
    begin
        op_state     = 1'b1;
        arith_req.op = OP_MUL;
        arith_a      = '0;
        arith_b      = '0;
        unique case (state_reg)
            S_B_KX:
            begin
                arith_a = 128'(acc_x_mag);
                arith_b = 128'(c_reg);
            end
            S_B_KY:
            begin
                arith_a = 128'(acc_y_mag);
                arith_b = 128'(c_reg);
            end
            S_B_DX:
            begin
                arith_a = 128'(vel_x_mag);
                arith_b = 128'(ts_reg);
            end
            S_B_DY:
            begin
                arith_a = 128'(vel_y_mag);
                arith_b = 128'(ts_reg);
            end
            S_P_SQX:
            begin
                arith_a = 128'(rx_mag);
                arith_b = 128'(rx_mag);
            end
            S_P_SQY:
            begin
                arith_a = 128'(ry_mag);
                arith_b = 128'(ry_mag);
            end
            S_P_SQRT:
            begin
                arith_req.op = OP_SQRT;
                arith_a      = 128'(d2_reg);
            end
            S_P_DEN:
            begin
                arith_a = 128'(d2_reg);
                arith_b = 128'(s_reg);
            end
            S_P_NUM:
            begin
                arith_a = 128'(m_sel);
                arith_b = 128'(rc_mag);
            end
            S_P_DIV:
            begin
                arith_req.op = OP_DIV;
                arith_a      = num_reg;
                arith_b      = den_reg;
            end
            default: op_state = 1'b0;
        endcase
        arith_req.start = op_state && !issued_reg;
    end

    nlg_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (arith_req),
        .a      (arith_a),
        .b      (arith_b),
        .done   (arith_done),
        .result (arith_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept_in)
                begin
                    if (kind == KIND_ADD)
                        state_next = S_ADD;
                    else if (count_reg != '0)
                        state_next = S_B_RD;
                end
            S_ADD:    if (out_free) state_next = S_IDLE;
            S_B_RD:   state_next = S_B_LD;
            S_B_LD:   state_next = S_B_KX;
            S_B_KX:   if (arith_done) state_next = S_B_KY;
            S_B_KY:   if (arith_done) state_next = ph3_reg ? S_B_OUT : S_B_DX;
            S_B_DX:   if (arith_done) state_next = S_B_DY;
            S_B_DY:   if (arith_done) state_next = S_B_WR;
            S_B_WR:
                if (i_last && (count_reg >= CNT_W'(2)))
                    state_next = S_P_RDI;
                else
                    state_next = S_B_RD;
            S_B_OUT:
                if (out_free)
                    state_next = i_last ? S_IDLE : S_B_RD;
            S_P_RDI:  state_next = S_P_LDI;
            S_P_LDI:  state_next = S_P_RDJ;
            S_P_RDJ:  state_next = S_P_LDJ;
            S_P_LDJ:  state_next = S_P_CHK;
            S_P_CHK:
                state_next = ((rx_reg == '0) && (ry_reg == '0)) ? S_P_NEXT : S_P_SQX;
            S_P_SQX:  if (arith_done) state_next = S_P_SQY;
            S_P_SQY:  if (arith_done) state_next = S_P_SQRT;
            S_P_SQRT: if (arith_done) state_next = S_P_DEN;
            S_P_DEN:  if (arith_done) state_next = S_P_NUM;
            S_P_NUM:  if (arith_done) state_next = S_P_DIV;
            S_P_DIV:
                if (arith_done)
                    state_next = (tsel_reg == 2'd3) ? S_P_WRI : S_P_NUM;
            S_P_WRI:  state_next = S_P_WRJ;
            S_P_WRJ:  state_next = S_P_NEXT;
            S_P_NEXT:
                state_next = (j_last && i2_last) ? S_B_RD : S_P_RDI;
            default:  state_next = S_IDLE;
        endcase
    end

    // state, loop counters, body count, configuration, issue flag, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            tsel_reg      <= '0;
            ph3_reg       <= 1'b0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            ts_reg        <= TIME_STEP_RST;
            gc_reg        <= GRAV_CONST_RST;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIME_STEP)
                    ts_reg <= cfg_data;
                else if (cfg_index == CFG_GRAV_CONST)
                    gc_reg <= cfg_data;
            end

            // arithmetic unit issue tracking
            if (arith_req.start)
                issued_reg <= 1'b1;
            else if (arith_done)
                issued_reg <= 1'b0;

            // result word valid
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    i_reg   <= '0;
                    ph3_reg <= 1'b0;
                end
                S_ADD:
                    if (out_free && !full)
                        count_reg <= count_reg + CNT_W'(1);
                S_B_WR:
                begin
                    if (!i_last)
                        i_reg <= i_reg + CNT_W'(1);
                    else if (count_reg >= CNT_W'(2))
                    begin
                        i_reg <= '0;
                        j_reg <= CNT_W'(1);
                    end
                    else
                    begin
                        i_reg   <= '0;
                        ph3_reg <= 1'b1;
                    end
                end
                S_B_OUT:
                    if (out_free && !i_last)
                        i_reg <= i_reg + CNT_W'(1);
                S_P_CHK:
                    tsel_reg <= '0;
                S_P_DIV:
                    if (arith_done)
                        tsel_reg <= tsel_reg + 2'd1;
                S_P_NEXT:
                begin
                    if (!j_last)
                        j_reg <= j_reg + CNT_W'(1);
                    else if (!i2_last)
                    begin
                        i_reg <= i_reg + CNT_W'(1);
                        j_reg <= i_reg + CNT_W'(2);
                    end
                    else
                    begin
                        i_reg   <= '0;
                        ph3_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = i_reg[IDX_W-1:0];
        mem_wdata = ei_reg;
        mem_raddr = (state_reg == S_P_RDJ) ? j_reg[IDX_W-1:0] : i_reg[IDX_W-1:0];
        case (state_reg)
            S_ADD:
            begin
                mem_we    = out_free && !full;
                mem_waddr = count_reg[IDX_W-1:0];
                mem_wdata = in_body_reg;
            end
            S_B_WR:
            begin
                mem_we          = 1'b1;
                mem_wdata.acc_x = '0;
                mem_wdata.acc_y = '0;
            end
            S_B_OUT:  mem_we = out_free;
            S_P_WRI:  mem_we = 1'b1;
            S_P_WRJ:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[IDX_W-1:0];
                mem_wdata = ej_reg;
            end
            default:
            begin
            end
        endcase
    end

    // body memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // working registers of the sequencer
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_body_reg.mass  <= mass;
            in_body_reg.pos_x <= pos_x;
            in_body_reg.pos_y <= pos_y;
            in_body_reg.vel_x <= vel_x;
            in_body_reg.vel_y <= vel_y;
            in_body_reg.acc_x <= '0;
            in_body_reg.acc_y <= '0;
            c_reg             <= gc_reg * ts_reg;
        end

        case (state_reg)
            S_B_LD, S_P_LDI: ei_reg <= rd_data_reg;
            S_P_LDJ:
            begin
                ej_reg <= rd_data_reg;
                rx_reg <= {rd_data_reg.pos_x[31], rd_data_reg.pos_x}
                        - {ei_reg.pos_x[31], ei_reg.pos_x};
                ry_reg <= {rd_data_reg.pos_y[31], rd_data_reg.pos_y}
                        - {ei_reg.pos_y[31], ei_reg.pos_y};
            end
            S_B_KX:
                if (arith_done)
                    ei_reg.vel_x <= add_sat32(ei_reg.vel_x, ei_reg.acc_x[47], kick_mag);
            S_B_KY:
                if (arith_done)
                    ei_reg.vel_y <= add_sat32(ei_reg.vel_y, ei_reg.acc_y[47], kick_mag);
            S_B_DX:
                if (arith_done)
                    ei_reg.pos_x <= add_sat32(ei_reg.pos_x, ei_reg.vel_x[31], drift_mag);
            S_B_DY:
                if (arith_done)
                    ei_reg.pos_y <= add_sat32(ei_reg.pos_y, ei_reg.vel_y[31], drift_mag);
            S_P_SQX:  if (arith_done) d2_reg <= arith_res[65:0];
            S_P_SQY:  if (arith_done) d2_reg <= d2_reg + arith_res[65:0];
            S_P_SQRT: if (arith_done) s_reg <= arith_res[33:0];
            S_P_DEN:  if (arith_done) den_reg <= arith_res;
            S_P_NUM:  if (arith_done) num_reg <= {arith_res[95:0], 32'd0};
            S_P_DIV:
                if (arith_done)
                begin
                    case (tsel_reg)
                        2'd0:    ei_reg.acc_x <= acc_new;
                        2'd1:    ei_reg.acc_y <= acc_new;
                        2'd2:    ej_reg.acc_x <= acc_new;
                        default: ej_reg.acc_y <= acc_new;
                    endcase
                end
            default:
            begin
            end
        endcase

        // result word payload
        if (load_out)
        begin
            if (state_reg == S_ADD)
            begin
                idx_out_reg   <= full ? 6'd0 : 6'(count_reg);
                mass_out_reg  <= in_body_reg.mass;
                pos_x_out_reg <= in_body_reg.pos_x;
                pos_y_out_reg <= in_body_reg.pos_y;
                vel_x_out_reg <= in_body_reg.vel_x;
                vel_y_out_reg <= in_body_reg.vel_y;
                status_reg    <= full ? STATUS_FULL : STATUS_OK;
                last_reg      <= 1'b1;
            end
            else
            begin
                idx_out_reg   <= 6'(i_reg);
                mass_out_reg  <= ei_reg.mass;
                pos_x_out_reg <= ei_reg.pos_x;
                pos_y_out_reg <= ei_reg.pos_y;
                vel_x_out_reg <= ei_reg.vel_x;
                vel_y_out_reg <= ei_reg.vel_y;
                status_reg    <= STATUS_OK;
                last_reg      <= i_last;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign body_index = idx_out_reg;
    assign mass_out   = mass_out_reg;
    assign pos_x_out  = pos_x_out_reg;
    assign pos_y_out  = pos_y_out_reg;
    assign vel_x_out  = vel_x_out_reg;
    assign vel_y_out  = vel_y_out_reg;
    assign status     = status_reg;
    assign last       = last_reg;

`ifndef ASSERT_OFF
    // body count never exceeds the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BODIES))
        else $error("body count beyond table size");

    // a finished operation is always one that was issued
    a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
        arith_done |-> issued_reg)
        else $error("arithmetic done without a request");

    // a new result word never overwrites one not yet taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten");

    // pair reads always take the second body above the first
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P_RDJ) |-> ((j_reg > i_reg) && (j_reg < count_reg)))
        else $error("pair index out of order");
`endif

endmodule
